FILE: hw/rtl/dmft_pkg.sv
// ----------------------------------------------------------------------------
// dmft_pkg
// Types and constants shared by the forward-frame Manchester transmitter:
// transaction payload structs, function codes and request status codes.
// ----------------------------------------------------------------------------
package dmft_pkg;

	// Input function codes
	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_SEND = 2'd1;
	localparam logic [1:0] FUNC_EDGE = 2'd2;

	// Request status codes
	localparam logic [1:0] STATUS_NONE     = 2'd0;
	localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
	localparam logic [1:0] STATUS_REJECTED = 2'd2;

	// Idle gap register reset value, in half-bit ticks
	localparam logic [7:0] IDLE_GAP_RESET = 8'd22;

	// Idle counter saturation value
	localparam logic [7:0] IDLE_COUNT_MAX = 8'hFF;

	// Bits per byte of the frame
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] frame_address;
		logic [7:0] frame_payload;
	} dmft_in_t;

	typedef struct packed {
		logic       line_level;
		logic       busy_res;
		logic [1:0] request_status;
	} dmft_out_t;

endpackage

FILE: hw/rtl/dali_manchester_frame_transmitter.sv
// ----------------------------------------------------------------------------
// dali_manchester_frame_transmitter
// Forward-frame Manchester transmitter: start bit, address byte, data byte,
// MSB first, two stop bits, paced by half-bit tick transactions.
// ----------------------------------------------------------------------------
// Each input transaction is a half-bit tick, a send request or a bus edge
// report, and each produces exactly one result transaction carrying the
// driven line level, the busy flag and the request status. The block takes
// one transaction per clock while the output is not stalled: an input
// register feeds the framer update, whose result goes to an output register
// as the transaction leaves the input register. The framer state advances
// as a transaction moves from the input register to the output register, so
// back-to-back transactions see each other's effects in order. A stalled
// output holds the input register; in_ready drops only when both registers
// are full and out_ready is low. The user must write idle_gap_q through
// cfg_we/cfg_wdata while no transaction is in flight; nothing enforces it.
// ----------------------------------------------------------------------------
module dali_manchester_frame_transmitter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dmft_pkg::dmft_in_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output dmft_pkg::dmft_out_t out_data,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata
);

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_START   = 4'd1,
		PH_START_X = 4'd2,
		PH_ABIT    = 4'd3,
		PH_ABIT_X  = 4'd4,
		PH_DBIT    = 4'd5,
		PH_DBIT_X  = 4'd6,
		PH_STOP1   = 4'd7,
		PH_STOP1_X = 4'd8,
		PH_STOP2   = 4'd9,
		PH_STOP2_X = 4'd10,
		PH_STOP3   = 4'd11
	} phase_t;

	// Configuration
	logic [7:0] idle_gap_q;

	// Framer state
	phase_t     phase_q, phase_d, phase_cur;
	logic [7:0] addr_q, addr_d;
	logic [7:0] payload_q, payload_d;
	logic [3:0] bit_pos_q, bit_pos_d;
	logic [7:0] idle_cnt_q, idle_cnt_d;
	logic       level_q, level_d;
	logic [1:0] status_d;

	// Pipeline
	logic               valid_s1;
	dmft_pkg::dmft_in_t data_s1;
	logic               valid_s2;
	dmft_pkg::dmft_out_t data_s2;
	logic               adv_s2;
	logic               fire_s1;

	// Helpers
	logic [7:0] idle_inc;
	logic [3:0] bit_pos_inc;
	logic       address_bit;
	logic       payload_bit;

	// Handshake
	assign adv_s2   = !valid_s2 || out_ready;
	assign fire_s1  = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;
	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	// Current bit of each byte, MSB first
	assign address_bit = addr_q[3'd7 - bit_pos_q[2:0]];
	assign payload_bit = payload_q[3'd7 - bit_pos_q[2:0]];
	assign bit_pos_inc = bit_pos_q + 4'd1;
	assign idle_inc    = (idle_cnt_q != dmft_pkg::IDLE_COUNT_MAX) ?
		idle_cnt_q + 8'd1 : idle_cnt_q;

	// Unused phase codes behave as idle
	assign phase_cur = (phase_q > PH_STOP3) ? PH_IDLE : phase_q;

	// Framer next state for the transaction in the input register
	always_comb begin
		phase_d    = phase_cur;
		addr_d     = addr_q;
		payload_d  = payload_q;
		bit_pos_d  = bit_pos_q;
		idle_cnt_d = idle_cnt_q;
		level_d    = level_q;
		status_d   = dmft_pkg::STATUS_NONE;
		case (data_s1.func)
			dmft_pkg::FUNC_TICK: begin
				idle_cnt_d = idle_inc;
				unique case (phase_cur)
					PH_START: begin
						if (idle_inc >= idle_gap_q) begin
							level_d = 1'b0;
							phase_d = PH_START_X;
						end
					end
					PH_START_X: begin
						level_d   = 1'b1;
						bit_pos_d = 4'd0;
						phase_d   = PH_ABIT;
					end
					PH_ABIT: begin
						level_d = !address_bit;
						phase_d = PH_ABIT_X;
					end
					PH_ABIT_X: begin
						level_d = address_bit;
						if (bit_pos_inc < dmft_pkg::BITS_PER_BYTE) begin
							bit_pos_d = bit_pos_inc;
							phase_d   = PH_ABIT;
						end else begin
							bit_pos_d = 4'd0;
							phase_d   = PH_DBIT;
						end
					end
					PH_DBIT: begin
						level_d = !payload_bit;
						phase_d = PH_DBIT_X;
					end
					PH_DBIT_X: begin
						level_d   = payload_bit;
						bit_pos_d = bit_pos_inc;
						phase_d   = (bit_pos_inc < dmft_pkg::BITS_PER_BYTE) ?
							PH_DBIT : PH_STOP1;
					end
					PH_STOP1: begin
						level_d = 1'b1;
						phase_d = PH_STOP1_X;
					end
					PH_STOP1_X: phase_d = PH_STOP2;
					PH_STOP2:   phase_d = PH_STOP2_X;
					PH_STOP2_X: phase_d = PH_STOP3;
					PH_STOP3: begin
						idle_cnt_d = 8'd0;
						phase_d    = PH_IDLE;
					end
					default: phase_d = PH_IDLE;
				endcase
			end
			dmft_pkg::FUNC_SEND: begin
				if (phase_cur != PH_IDLE) begin
					status_d = dmft_pkg::STATUS_REJECTED;
				end else begin
					addr_d    = data_s1.frame_address;
					payload_d = data_s1.frame_payload;
					phase_d   = PH_START;
					status_d  = dmft_pkg::STATUS_ACCEPTED;
				end
			end
			dmft_pkg::FUNC_EDGE: idle_cnt_d = 8'd0;
			default: ;
		endcase
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_gap_q <= dmft_pkg::IDLE_GAP_RESET;
		end else if (cfg_we) begin
			idle_gap_q <= cfg_wdata;
		end
	end

	// Framer state and pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			addr_q     <= 8'd0;
			payload_q  <= 8'd0;
			bit_pos_q  <= 4'd0;
			idle_cnt_q <= 8'd0;
			level_q    <= 1'b1;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (fire_s1) begin
				phase_q    <= phase_d;
				addr_q     <= addr_d;
				payload_q  <= payload_d;
				bit_pos_q  <= bit_pos_d;
				idle_cnt_q <= idle_cnt_d;
				level_q    <= level_d;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
		if (fire_s1) begin
			data_s2.line_level     <= level_d;
			data_s2.busy_res       <= (phase_d != PH_IDLE);
			data_s2.request_status <= status_d;
		end
	end

	// An accepted send always reports busy
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.request_status == dmft_pkg::STATUS_ACCEPTED
		|-> out_data.busy_res)
		else $error("accepted send without busy");

	// The line rests high whenever the framer is idle
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> level_q)
		else $error("line low while idle");

	// Input stalls only when both registers are full and the output is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled without backpressure");

	// Bit position never passes the byte length
	assert property (@(posedge clk) disable iff (!arst_n)
		bit_pos_q <= dmft_pkg::BITS_PER_BYTE)
		else $error("bit position out of range");

	// Framer state moves only when a transaction advances
	assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> $stable(phase_q) && $stable(idle_cnt_q) && $stable(level_q))
		else $error("framer state changed without a transaction");

endmodule
